/* design/one_shot_sampler_voice_top_macros.svh */
// ----------------------------------------------------------------------------
// One-shot sampler voice assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef ONE_SHOT_SAMPLER_VOICE_TOP_MACROS_SVH
`define ONE_SHOT_SAMPLER_VOICE_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and ignored during reset.
`define OSV_ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("one_shot_sampler_voice assertion failed");

// Next-cycle implication, sampled on clk and ignored during reset.
`define OSV_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("one_shot_sampler_voice assertion failed");

`endif

/* design/osv_pkg.sv */
// ----------------------------------------------------------------------------
// One-shot sampler voice package
// Constants, payload types, controller states and shared helper functions.
// ----------------------------------------------------------------------------
package osv_pkg;

	localparam int VOICE_COUNT = 16;
	localparam int FRAME_DEPTH = 65536;
	localparam int SAMPLE_BITS = 16;

	localparam int VOICE_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
	localparam int ADDR_W = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 18;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	typedef enum logic [1:0] {
		OP_LOAD     = 2'd0,
		OP_NOTE_ON  = 2'd1,
		OP_NOTE_OFF = 2'd2,
		OP_TICK     = 2'd3
	} opcode_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_VOLUME     = 3'd0,
		REG_BASE_INC   = 3'd1,
		REG_GATE_STEP  = 3'd2,
		REG_SAMPLE_LEN = 3'd3,
		REG_ROOT_NOTE  = 3'd4
	} reg_index_t;

	typedef struct packed {
		opcode_t            opcode;
		logic [3:0]         voice;
		logic [6:0]         note;
		logic [15:0]        frame_address;
		logic signed [15:0] left_word;
		logic signed [15:0] right_word;
		logic signed [15:0] fm_in;
		logic [15:0]        env_in;
		logic               env_connected;
		logic               voice_muted;
	} in_item_t;

	typedef struct packed {
		logic [3:0]         voice_out;
		logic signed [15:0] left_out;
		logic signed [15:0] right_out;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_LOAD,
		ST_NOTE_DIV,
		ST_NOTE_MUL,
		ST_NOTE_WRITE,
		ST_NOTE_OFF,
		ST_TICK_RD0,
		ST_TICK_RD1,
		ST_TICK_INTERP,
		ST_TICK_GAIN,
		ST_TICK_VOL,
		ST_TICK_OUT
	} state_t;

	typedef struct packed {
		logic capture;
		logic mem_write;
		logic note_div;
		logic note_mul;
		logic note_write;
		logic note_off;
		logic tick_update;
		logic rd_next;
		logic latch_a;
		logic interp;
		logic mul_gain;
		logic mul_vol;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		opcode_t opcode;
		logic    tick_active;
		logic    out_free;
	} status_t;

	function automatic logic [16:0] semitone_q16(input logic [3:0] idx);
		logic [16:0] r;
		unique case (idx)
			4'd0:    r = 17'd65536;
			4'd1:    r = 17'd69433;
			4'd2:    r = 17'd73562;
			4'd3:    r = 17'd77936;
			4'd4:    r = 17'd82570;
			4'd5:    r = 17'd87480;
			4'd6:    r = 17'd92682;
			4'd7:    r = 17'd98193;
			4'd8:    r = 17'd104032;
			4'd9:    r = 17'd110218;
			4'd10:   r = 17'd116772;
			4'd11:   r = 17'd123715;
			default: r = 17'd65536;
		endcase
		return r;
	endfunction

	// Scales a 16-bit word to the store width, flooring when narrowing.
	function automatic sample_t to_store(input logic signed [15:0] w);
		logic signed [39:0] wide;
		logic signed [39:0] shifted;
		wide = 40'(w) <<< 24;
		shifted = wide >>> (40 - SAMPLE_BITS);
		return sample_t'(shifted);
	endfunction

endpackage

/* design/osv_ctrl.sv */
// ----------------------------------------------------------------------------
// One-shot sampler voice controller
// Sequences load, note and tick items through the datapath one at a time.
// ----------------------------------------------------------------------------
module osv_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  osv_pkg::status_t status,
	output osv_pkg::cmd_t    cmd
);

	osv_pkg::state_t state_q;
	osv_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= osv_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			osv_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = osv_pkg::ST_DECODE;
				end
			end
			osv_pkg::ST_DECODE: begin
				unique case (status.opcode)
					osv_pkg::OP_LOAD:     state_d = osv_pkg::ST_LOAD;
					osv_pkg::OP_NOTE_ON:  state_d = osv_pkg::ST_NOTE_DIV;
					osv_pkg::OP_NOTE_OFF: state_d = osv_pkg::ST_NOTE_OFF;
					osv_pkg::OP_TICK:     state_d = osv_pkg::ST_TICK_RD0;
					default:              state_d = osv_pkg::ST_IDLE;
				endcase
			end
			osv_pkg::ST_LOAD:       state_d = osv_pkg::ST_IDLE;
			osv_pkg::ST_NOTE_DIV:   state_d = osv_pkg::ST_NOTE_MUL;
			osv_pkg::ST_NOTE_MUL:   state_d = osv_pkg::ST_NOTE_WRITE;
			osv_pkg::ST_NOTE_WRITE: state_d = osv_pkg::ST_IDLE;
			osv_pkg::ST_NOTE_OFF:   state_d = osv_pkg::ST_IDLE;
			osv_pkg::ST_TICK_RD0: begin
				state_d = status.tick_active ? osv_pkg::ST_TICK_RD1 : osv_pkg::ST_TICK_OUT;
			end
			osv_pkg::ST_TICK_RD1:    state_d = osv_pkg::ST_TICK_INTERP;
			osv_pkg::ST_TICK_INTERP: state_d = osv_pkg::ST_TICK_GAIN;
			osv_pkg::ST_TICK_GAIN:   state_d = osv_pkg::ST_TICK_VOL;
			osv_pkg::ST_TICK_VOL:    state_d = osv_pkg::ST_TICK_OUT;
			osv_pkg::ST_TICK_OUT: begin
				if (status.out_free) begin
					state_d = osv_pkg::ST_IDLE;
				end
			end
			default: state_d = osv_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			osv_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.capture = in_valid;
			end
			osv_pkg::ST_LOAD:        cmd.mem_write = 1'b1;
			osv_pkg::ST_NOTE_DIV:    cmd.note_div = 1'b1;
			osv_pkg::ST_NOTE_MUL:    cmd.note_mul = 1'b1;
			osv_pkg::ST_NOTE_WRITE:  cmd.note_write = 1'b1;
			osv_pkg::ST_NOTE_OFF:    cmd.note_off = 1'b1;
			osv_pkg::ST_TICK_RD0:    cmd.tick_update = 1'b1;
			osv_pkg::ST_TICK_RD1: begin
				cmd.rd_next = 1'b1;
				cmd.latch_a = 1'b1;
			end
			osv_pkg::ST_TICK_INTERP: cmd.interp = 1'b1;
			osv_pkg::ST_TICK_GAIN:   cmd.mul_gain = 1'b1;
			osv_pkg::ST_TICK_VOL:    cmd.mul_vol = 1'b1;
			osv_pkg::ST_TICK_OUT:    cmd.out_load = status.out_free;
			default: begin
			end
		endcase
	end

endmodule

/* design/osv_dp.sv */
// ----------------------------------------------------------------------------
// One-shot sampler voice datapath
// Sample store, per-voice state, pitch, interpolation and gain arithmetic,
// configuration registers and the output register.
// ----------------------------------------------------------------------------
module osv_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  osv_pkg::in_item_t                   in_item,
	input  logic                                cfg_write,
	input  logic [osv_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [osv_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  osv_pkg::cmd_t                       cmd,
	output osv_pkg::status_t                    status,
	output logic                                out_valid,
	input  logic                                out_ready,
	output osv_pkg::out_item_t                  out_item
);

	localparam int SB = osv_pkg::SAMPLE_BITS;
	localparam int SH = SB + 15;
	localparam logic signed [SB+34:0] RND = (SB + 35)'(1) <<< (SH - 1);
	localparam logic signed [SB+34:0] SAT_HI = (SB + 35)'(32767);
	localparam logic signed [SB+34:0] SAT_LO = -(SB + 35)'(32768);

	logic [15:0] vol_q;
	logic [17:0] base_q;
	logic [16:0] step_q;
	logic [16:0] len_q;
	logic [6:0]  root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vol_q  <= 16'd26214;
			base_q <= 18'd65536;
			step_q <= 17'd137;
			len_q  <= 17'd0;
			root_q <= 7'd60;
		end else if (cfg_write) begin
			unique case (cfg_index)
				osv_pkg::REG_VOLUME:     vol_q  <= cfg_data[15:0];
				osv_pkg::REG_BASE_INC:   base_q <= cfg_data[17:0];
				osv_pkg::REG_GATE_STEP:  step_q <= cfg_data[16:0];
				osv_pkg::REG_SAMPLE_LEN: len_q  <= cfg_data[16:0];
				osv_pkg::REG_ROOT_NOTE:  root_q <= cfg_data[6:0];
				default: begin
				end
			endcase
		end
	end

	osv_pkg::in_item_t item_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= in_item;
		end
	end

	logic                       voice_ok;
	logic [osv_pkg::VOICE_W-1:0] vidx;
	assign voice_ok = 32'(item_q.voice) < osv_pkg::VOICE_COUNT;
	assign vidx = osv_pkg::VOICE_W'(item_q.voice);

	logic [31:0] pos_q  [osv_pkg::VOICE_COUNT];
	logic [23:0] inc_q  [osv_pkg::VOICE_COUNT];
	logic [16:0] gate_q [osv_pkg::VOICE_COUNT];
	logic        held_q [osv_pkg::VOICE_COUNT];

	// Pitch increment: octave and semitone split, then scaled and rounded.
	logic [8:0]  u_d;
	logic [16:0] qm_d;
	logic [8:0]  u_q;
	logic [4:0]  q_q;
	logic [8:0]  q12;
	logic [3:0]  semi;
	logic [34:0] p_q;
	logic [5:0]  rs_q;
	logic [45:0] pt;
	logic [45:0] pr;
	logic [23:0] inc_new;

	assign u_d = 9'(item_q.note) + 9'd132 - 9'(root_q);
	assign qm_d = 17'(u_d) * 17'd171;
	assign q12 = (9'(q_q) << 3) + (9'(q_q) << 2);
	assign semi = 4'(u_q - q12);
	assign pt = 46'({p_q, 10'd0}) + (46'(1) << (rs_q - 6'd1));
	assign pr = pt >> rs_q;
	assign inc_new = (pr > 46'hFFFFFF) ? 24'hFFFFFF : pr[23:0];

	always_ff @(posedge clk) begin
		if (cmd.note_div) begin
			u_q <= u_d;
			q_q <= qm_d[15:11];
		end
		if (cmd.note_mul) begin
			p_q  <= 35'(base_q) * 35'(osv_pkg::semitone_q16(semi));
			rs_q <= 6'd37 - 6'(q_q);
		end
	end

	// Tick: activity check, position advance and gate ramp.
	logic [31:0] pos_cur;
	logic [23:0] inc_cur;
	logic [16:0] gate_cur;
	logic [16:0] total;
	logic [32:0] limit;
	logic        active;
	logic signed [17:0] fsum;
	logic [15:0] fclamp;
	logic [39:0] adv;
	logic [32:0] np;
	logic [31:0] pos_new;
	logic [16:0] tgt;
	logic [16:0] gate_new;
	logic [15:0] env_sat;
	logic [16:0] gain_d;

	assign pos_cur  = pos_q[vidx];
	assign inc_cur  = inc_q[vidx];
	assign gate_cur = gate_q[vidx];
	assign total = (32'(len_q) > osv_pkg::FRAME_DEPTH) ? 17'(osv_pkg::FRAME_DEPTH) : len_q;
	assign limit = {total - 17'd1, 16'd0};
	assign active = voice_ok && !item_q.voice_muted && (total >= 17'd2)
		&& ({1'b0, pos_cur} < limit);

	assign fsum = 18'(item_q.fm_in) + 18'sd4096;
	assign fclamp = fsum[17] ? 16'd0 : fsum[15:0];
	assign adv = inc_cur * fclamp;
	assign np = {1'b0, pos_cur} + 33'(adv[39:12]);
	assign pos_new = np[32] ? 32'hFFFF_FFFF : np[31:0];

	assign tgt = held_q[vidx] ? 17'd65536 : 17'd0;
	always_comb begin
		gate_new = gate_cur;
		priority if (gate_cur < tgt) begin
			gate_new = ((tgt - gate_cur) <= step_q) ? tgt : gate_cur + step_q;
		end else if (gate_cur > tgt) begin
			gate_new = ((gate_cur - tgt) <= step_q) ? tgt : gate_cur - step_q;
		end
	end

	assign env_sat = (item_q.env_in > 16'd32768) ? 16'd32768 : item_q.env_in;
	assign gain_d = item_q.env_connected ? {env_sat, 1'b0} : gate_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < osv_pkg::VOICE_COUNT; i++) begin
				pos_q[i]  <= '0;
				inc_q[i]  <= '0;
				gate_q[i] <= '0;
				held_q[i] <= 1'b0;
			end
		end else begin
			if (cmd.note_write && voice_ok) begin
				pos_q[vidx]  <= '0;
				gate_q[vidx] <= '0;
				held_q[vidx] <= 1'b1;
				inc_q[vidx]  <= inc_new;
			end
			if (cmd.note_off && voice_ok) begin
				held_q[vidx] <= 1'b0;
			end
			if (cmd.tick_update && active) begin
				pos_q[vidx] <= pos_new;
				if (!item_q.env_connected) begin
					gate_q[vidx] <= gate_new;
				end
			end
		end
	end

	logic        active_q;
	logic [16:0] gain_q;
	logic [15:0] idx_q;
	logic [15:0] frac_q;

	always_ff @(posedge clk) begin
		if (cmd.tick_update) begin
			active_q <= active;
			gain_q   <= gain_d;
			idx_q    <= pos_cur[31:16];
			frac_q   <= pos_cur[15:0];
		end
	end

	// Sample store, left in the upper half of each word.
	logic [2*SB-1:0]               mem [osv_pkg::FRAME_DEPTH];
	logic [2*SB-1:0]               rd_q;
	logic [osv_pkg::ADDR_W-1:0]    rd_addr;
	logic                          addr_ok;

	assign addr_ok = 32'(item_q.frame_address) < osv_pkg::FRAME_DEPTH;
	assign rd_addr = cmd.rd_next ? osv_pkg::ADDR_W'(idx_q + 16'd1)
		: osv_pkg::ADDR_W'(pos_cur[31:16]);

	always_ff @(posedge clk) begin
		if (cmd.mem_write && addr_ok) begin
			mem[osv_pkg::ADDR_W'(item_q.frame_address)] <=
				{osv_pkg::to_store(item_q.left_word), osv_pkg::to_store(item_q.right_word)};
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
	end

	// Interpolation and gain chain, both channels side by side.
	osv_pkg::sample_t   la_q, ra_q, lb, rb, li_d, ri_d, li_q, ri_q;
	logic signed [SB:0] dl, dr;
	logic signed [SB+17:0] pl, pr_i;
	logic signed [17:0] gs;
	logic signed [SB+17:0] gl_q, gr_q;
	logic [15:0] vol_sat;
	logic signed [16:0] vs;
	logic signed [SB+34:0] vl_q, vr_q;
	logic signed [SB+34:0] yl, yr;
	logic signed [15:0] sl, sr;

	assign lb = osv_pkg::sample_t'(rd_q[2*SB-1:SB]);
	assign rb = osv_pkg::sample_t'(rd_q[SB-1:0]);
	assign dl = (SB + 1)'(lb) - (SB + 1)'(la_q);
	assign dr = (SB + 1)'(rb) - (SB + 1)'(ra_q);
	assign pl = dl * $signed({1'b0, frac_q});
	assign pr_i = dr * $signed({1'b0, frac_q});
	assign li_d = la_q + osv_pkg::sample_t'(pl >>> 16);
	assign ri_d = ra_q + osv_pkg::sample_t'(pr_i >>> 16);
	assign gs = $signed({1'b0, gain_q});
	assign vol_sat = (vol_q > 16'd32768) ? 16'd32768 : vol_q;
	assign vs = $signed({1'b0, vol_sat});
	assign yl = (vl_q + RND) >>> SH;
	assign yr = (vr_q + RND) >>> SH;
	assign sl = (yl > SAT_HI) ? 16'sh7FFF : (yl < SAT_LO) ? 16'sh8000 : 16'(yl);
	assign sr = (yr > SAT_HI) ? 16'sh7FFF : (yr < SAT_LO) ? 16'sh8000 : 16'(yr);

	always_ff @(posedge clk) begin
		if (cmd.latch_a) begin
			la_q <= osv_pkg::sample_t'(rd_q[2*SB-1:SB]);
			ra_q <= osv_pkg::sample_t'(rd_q[SB-1:0]);
		end
		if (cmd.interp) begin
			li_q <= li_d;
			ri_q <= ri_d;
		end
		if (cmd.mul_gain) begin
			gl_q <= li_q * gs;
			gr_q <= ri_q * gs;
		end
		if (cmd.mul_vol) begin
			vl_q <= gl_q * vs;
			vr_q <= gr_q * vs;
		end
	end

	logic               out_valid_q;
	osv_pkg::out_item_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.voice_out <= item_q.voice;
			out_q.left_out  <= active_q ? sl : 16'sd0;
			out_q.right_out <= active_q ? sr : 16'sd0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item = out_q;

	assign status.opcode = item_q.opcode;
	assign status.tick_active = active;
	assign status.out_free = !out_valid_q || out_ready;

endmodule

/* design/one_shot_sampler_voice_top.sv */
// One item is taken at a time. A tick reads the sample store through its
// single read port, once for each of the two neighboring frames, followed by
// the interpolation, gain and volume multiplies, each in a state of its own; a
// tick that yields a zero frame skips from the first read to the output. A
// tick also waits while the previous result still sits unaccepted in the
// output register; other items proceed regardless.
// ----------------------------------------------------------------------------
// One-shot sampler voice top level
// Polyphonic one-shot sample playback with linear interpolation.
// ----------------------------------------------------------------------------
`include "one_shot_sampler_voice_top_macros.svh"

module one_shot_sampler_voice_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  osv_pkg::in_item_t               in_item,
	output logic                            out_valid,
	input  logic                            out_ready,
	output osv_pkg::out_item_t              out_item,
	input  logic                            cfg_write,
	input  logic [osv_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [osv_pkg::CFG_DATA_W-1:0]  cfg_data
);

	osv_pkg::cmd_t    cmd;
	osv_pkg::status_t status;

	osv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	osv_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	`OSV_ASSERT_NEXT(a_busy_after_transfer, in_valid && in_ready, !in_ready)
	`OSV_ASSERT_IMPLIES(a_load_into_free_slot, cmd.out_load, !out_valid || out_ready)
	`OSV_ASSERT_IMPLIES(a_load_not_while_idle, cmd.out_load, !in_ready)

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// One-shot sampler voice testbench
// Drives a directed table of loads, notes, ticks and register writes, then
// random phases over several register settings. Each tick result is checked
// against a cycle-free model of voices and sample store, or a table value.
// ----------------------------------------------------------------------------
module testbench;

	typedef enum logic [0:0] {
		ROW_ITEM,
		ROW_REG
	} row_kind_t;

	typedef struct {
		row_kind_t           kind;
		osv_pkg::in_item_t   item;
		bit                  typed;
		osv_pkg::out_item_t  want;
		osv_pkg::reg_index_t idx;
		logic [17:0]         data;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	osv_pkg::in_item_t in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	osv_pkg::out_item_t out_item;
	logic cfg_write = 1'b0;
	logic [osv_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [osv_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	one_shot_sampler_voice_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// Mirror of the block's registers and state.
	logic [15:0] m_volume = 16'd26214;
	logic [17:0] m_base_inc = 18'd65536;
	logic [16:0] m_gate_step = 17'd137;
	logic [16:0] m_sample_len = 17'd0;
	logic [6:0] m_root = 7'd60;
	logic signed [15:0] left_frames [osv_pkg::FRAME_DEPTH];
	logic signed [15:0] right_frames [osv_pkg::FRAME_DEPTH];
	bit frame_written [osv_pkg::FRAME_DEPTH];
	logic [31:0] position [osv_pkg::VOICE_COUNT];
	logic [23:0] increment [osv_pkg::VOICE_COUNT];
	logic [16:0] gate_lvl [osv_pkg::VOICE_COUNT];
	bit gate_on [osv_pkg::VOICE_COUNT];

	osv_pkg::out_item_t expected_frames [$];
	row_t plan [$];
	int mismatches = 0;
	int idle_cycles = 0;
	int cyc = 0;
	int burst_left = 0;

	localparam int SEMITONE [12] = '{65536, 69433, 73562, 77936, 82570, 87480,
		92682, 98193, 104032, 110218, 116772, 123715};

	function automatic logic [23:0] note_increment(input logic [6:0] note);
		int k, oct, semi;
		longint unsigned p, r;
		k = int'(note) - int'(m_root);
		oct = (k >= 0) ? k / 12 : -((-k + 11) / 12);
		semi = k - oct * 12;
		p = longint'(m_base_inc) * SEMITONE[semi];
		if (oct >= 0) begin
			p = p << oct;
			r = (p + 32768) >> 16;
		end else begin
			r = (p + (64'd1 << (15 - oct))) >> (16 - oct);
		end
		return (r > 64'hFFFFFF) ? 24'hFFFFFF : r[23:0];
	endfunction

	function automatic logic signed [15:0] clip16(input longint x);
		if (x > 32767) return 16'sh7FFF;
		if (x < -32768) return 16'sh8000;
		return x[15:0];
	endfunction

	function automatic bit tick_plays(input osv_pkg::in_item_t it);
		longint unsigned total;
		total = (m_sample_len > osv_pkg::FRAME_DEPTH) ? osv_pkg::FRAME_DEPTH : m_sample_len;
		return !it.voice_muted && total >= 2 &&
			longint'(position[it.voice]) < ((total - 1) << 16);
	endfunction

	// Applies one accepted item to the mirror; returns 1 with a frame for ticks.
	function automatic bit voice_step(input osv_pkg::in_item_t it,
			output osv_pkg::out_item_t res);
		longint li, ri, la, lb, ra, rb, frac, f, gain, vol, np, tgt, g;
		int unsigned v;
		v = 32'(it.voice);
		res = '0;
		res.voice_out = it.voice;
		case (it.opcode)
			osv_pkg::OP_LOAD: begin
				left_frames[it.frame_address] = it.left_word;
				right_frames[it.frame_address] = it.right_word;
				frame_written[it.frame_address] = 1'b1;
				return 1'b0;
			end
			osv_pkg::OP_NOTE_ON: begin
				position[v] = '0;
				gate_lvl[v] = '0;
				gate_on[v] = 1'b1;
				increment[v] = note_increment(it.note);
				return 1'b0;
			end
			osv_pkg::OP_NOTE_OFF: begin
				gate_on[v] = 1'b0;
				return 1'b0;
			end
			default: begin
				if (!tick_plays(it))
					return 1'b1;
				frac = position[v][15:0];
				la = left_frames[position[v][31:16]];
				lb = left_frames[position[v][31:16] + 1];
				ra = right_frames[position[v][31:16]];
				rb = right_frames[position[v][31:16] + 1];
				li = la + (((lb - la) * frac) >>> 16);
				ri = ra + (((rb - ra) * frac) >>> 16);
				f = 4096 + longint'(it.fm_in);
				if (f < 0)
					f = 0;
				np = longint'(position[v]) + ((longint'(increment[v]) * f) >>> 12);
				position[v] = (np > 64'hFFFFFFFF) ? 32'hFFFFFFFF : np[31:0];
				if (it.env_connected) begin
					gain = (it.env_in > 32768) ? 65536 : longint'(it.env_in) * 2;
				end else begin
					g = gate_lvl[v];
					tgt = gate_on[v] ? 65536 : 0;
					if (g < tgt)
						g = (tgt - g <= m_gate_step) ? tgt : g + m_gate_step;
					else if (g > tgt)
						g = (g - tgt <= m_gate_step) ? tgt : g - m_gate_step;
					gate_lvl[v] = g[16:0];
					gain = g;
				end
				vol = (m_volume > 32768) ? 32768 : m_volume;
				res.left_out = clip16((li * gain * vol + (64'sd1 <<< 30)) >>> 31);
				res.right_out = clip16((ri * gain * vol + (64'sd1 <<< 30)) >>> 31);
				return 1'b1;
			end
		endcase
	endfunction

	function automatic osv_pkg::in_item_t make_item(input osv_pkg::opcode_t op,
			input int voice, input int note,
			input int addr, input int lw, input int rw, input int fm, input int env,
			input bit env_c, input bit mute);
		osv_pkg::in_item_t it;
		it.opcode = op;
		it.voice = voice[3:0];
		it.note = note[6:0];
		it.frame_address = addr[15:0];
		it.left_word = lw[15:0];
		it.right_word = rw[15:0];
		it.fm_in = fm[15:0];
		it.env_in = env[15:0];
		it.env_connected = env_c;
		it.voice_muted = mute;
		return it;
	endfunction

	function automatic void add_item(input osv_pkg::in_item_t it, input bit typed = 1'b0,
			input osv_pkg::out_item_t want = '0);
		row_t r;
		r.kind = ROW_ITEM;
		r.item = it;
		r.typed = typed;
		r.want = want;
		r.idx = osv_pkg::REG_VOLUME;
		r.data = '0;
		plan.push_back(r);
	endfunction

	function automatic void add_reg(input osv_pkg::reg_index_t idx, input int data);
		row_t r;
		r.kind = ROW_REG;
		r.item = '0;
		r.typed = 1'b0;
		r.want = '0;
		r.idx = idx;
		r.data = data[17:0];
		plan.push_back(r);
	endfunction

	// Sender pacing: bursts of random length separated by random gaps.
	task automatic pace();
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
	endtask

	task automatic send(input osv_pkg::in_item_t it, input bit typed = 1'b0,
			input osv_pkg::out_item_t want = '0);
		osv_pkg::out_item_t res;
		pace();
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (!in_ready);
		if (voice_step(it, res))
			expected_frames.push_back(typed ? want : res);
	endtask

	// Waits until every result is back, then lets an item without a result finish.
	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		while (expected_frames.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(input osv_pkg::reg_index_t idx, input int data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data[17:0];
		@(posedge clk);
		case (idx)
			osv_pkg::REG_VOLUME:     m_volume = data[15:0];
			osv_pkg::REG_BASE_INC:   m_base_inc = data[17:0];
			osv_pkg::REG_GATE_STEP:  m_gate_step = data[16:0];
			osv_pkg::REG_SAMPLE_LEN: m_sample_len = data[16:0];
			osv_pkg::REG_ROOT_NOTE:  m_root = data[6:0];
			default: ;
		endcase
	endtask

	function automatic int rand_word();
		case ($urandom_range(0, 5))
			0: return 32767;
			1: return -32768;
			default: return int'($urandom_range(0, 65535)) - 32768;
		endcase
	endfunction

	function automatic osv_pkg::in_item_t random_item(input int span);
		osv_pkg::in_item_t it;
		int sel;
		sel = $urandom_range(0, 99);
		it = make_item(osv_pkg::OP_TICK, $urandom_range(0, 15), $urandom_range(0, 127),
			$urandom_range(0, 65535), rand_word(), rand_word(), 0,
			$urandom_range(0, 65535), 1'($urandom_range(0, 1)), $urandom_range(0, 9) == 0);
		if ($urandom_range(0, 2) == 0)
			it.fm_in = 16'($urandom_range(0, 65535));
		else
			it.fm_in = 16'(int'($urandom_range(0, 8191)) - 4096);
		if ($urandom_range(0, 3) == 0)
			it.env_in = 16'($urandom_range(0, 32768));
		if (sel < 10) begin
			it.opcode = osv_pkg::OP_LOAD;
			if (span > 0 && $urandom_range(0, 3) != 0)
				it.frame_address = 16'($urandom_range(0, span - 1));
			if ($urandom_range(0, 4) == 0)
				it.right_word = it.left_word;
		end else if (sel < 22) begin
			it.opcode = osv_pkg::OP_NOTE_ON;
		end else if (sel < 30) begin
			it.opcode = osv_pkg::OP_NOTE_OFF;
		end else if (tick_plays(it) && (!frame_written[position[it.voice][31:16]] ||
				!frame_written[position[it.voice][31:16] + 1])) begin
			it.voice_muted = 1'b1;
		end
		return it;
	endfunction

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else if (arst_n)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= 5000) begin
			$display("testbench: errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		osv_pkg::out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_frames.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < 10)
					$display("unexpected frame %p", out_item);
			end else begin
				want = expected_frames.pop_front();
				if (want.voice_out !== out_item.voice_out || want.left_out !== out_item.left_out
						|| want.right_out !== out_item.right_out) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("frame mismatch: expected %p, got %p", want, out_item);
				end
			end
		end
		case ((cyc / 256) % 4)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			2: out_ready <= ($urandom_range(0, 7) == 0);
			default: out_ready <= (cyc % 5 != 0);
		endcase
	end

	initial begin
		int span, len, items;
		osv_pkg::in_item_t it;
		foreach (position[i]) begin
			position[i] = '0;
			increment[i] = '0;
			gate_lvl[i] = '0;
			gate_on[i] = 1'b0;
		end

		add_item(make_item(osv_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
			'{4'd0, 16'sd0, 16'sd0});
		add_item(make_item(osv_pkg::OP_TICK, 15, 0, 0, 0, 0, 0, 32768, 1, 1), 1'b1,
			'{4'd15, 16'sd0, 16'sd0});
		add_item(make_item(osv_pkg::OP_LOAD, 0, 0, 0, 32767, -32768, 0, 0, 0, 0));
		add_item(make_item(osv_pkg::OP_LOAD, 0, 0, 1, -32768, 32767, 0, 0, 0, 0));
		add_item(make_item(osv_pkg::OP_LOAD, 0, 0, 2, 0, -1, 0, 0, 0, 0));
		add_item(make_item(osv_pkg::OP_LOAD, 0, 0, 65535, -1, 0, 0, 0, 0, 0));
		add_item(make_item(osv_pkg::OP_LOAD, 0, 0, 3, 12345, 12345, 0, 0, 0, 0));
		add_reg(osv_pkg::REG_SAMPLE_LEN, 4);
		add_reg(osv_pkg::REG_VOLUME, 32768);
		add_reg(osv_pkg::REG_GATE_STEP, 65536);
		add_item(make_item(osv_pkg::OP_NOTE_ON, 0, 60, 0, 0, 0, 0, 0, 0, 0));
		add_item(make_item(osv_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 32768, 1, 0), 1'b1,
			'{4'd0, 16'sh7FFF, 16'sh8000});
		add_item(make_item(osv_pkg::OP_TICK, 0, 0, 0, 0, 0, -32768, 65535, 1, 0));
		add_item(make_item(osv_pkg::OP_TICK, 0, 0, 0, 0, 0, 32767, 0, 0, 0));
		add_item(make_item(osv_pkg::OP_NOTE_OFF, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		add_item(make_item(osv_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		add_item(make_item(osv_pkg::OP_NOTE_ON, 15, 127, 0, 0, 0, 0, 0, 0, 0));
		add_item(make_item(osv_pkg::OP_TICK, 15, 0, 0, 0, 0, 0, 0, 0, 1), 1'b1,
			'{4'd15, 16'sd0, 16'sd0});
		add_item(make_item(osv_pkg::OP_TICK, 15, 0, 0, 0, 0, 4095, 0, 0, 0));
		add_item(make_item(osv_pkg::OP_NOTE_ON, 1, 0, 0, 0, 0, 0, 0, 0, 0));
		add_item(make_item(osv_pkg::OP_TICK, 1, 0, 0, 0, 0, 32767, 12000, 1, 0));
		add_reg(osv_pkg::REG_SAMPLE_LEN, 1);
		add_item(make_item(osv_pkg::OP_TICK, 1, 0, 0, 0, 0, 0, 32768, 1, 0), 1'b1,
			'{4'd1, 16'sd0, 16'sd0});

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_REG) begin
				if (i == 0 || plan[i - 1].kind != ROW_REG)
					drain();
				write_reg(plan[i].idx, int'(plan[i].data));
				if (i + 1 >= plan.size() || plan[i + 1].kind != ROW_REG)
					cfg_write <= 1'b0;
			end else begin
				send(plan[i].item, plan[i].typed, plan[i].want);
			end
		end

		for (int phase = 0; phase < 9; phase++) begin
			drain();
			case (phase % 4)
				0: write_reg(osv_pkg::REG_VOLUME, 32768);
				1: write_reg(osv_pkg::REG_VOLUME, 0);
				2: write_reg(osv_pkg::REG_VOLUME, 65535);
				default: write_reg(osv_pkg::REG_VOLUME, $urandom_range(0, 65535));
			endcase
			case (phase % 3)
				0: write_reg(osv_pkg::REG_BASE_INC, $urandom_range(4096, 131072));
				1: write_reg(osv_pkg::REG_BASE_INC, (phase == 4) ? 262143 : 0);
				default: write_reg(osv_pkg::REG_BASE_INC, $urandom_range(0, 262143));
			endcase
			case (phase % 3)
				0: write_reg(osv_pkg::REG_GATE_STEP, $urandom_range(0, 4096));
				1: write_reg(osv_pkg::REG_GATE_STEP, 0);
				default: write_reg(osv_pkg::REG_GATE_STEP, (phase == 5) ? 131071 : 65536);
			endcase
			case (phase)
				2: len = 65536;
				3: len = 0;
				6: len = 131071;
				7: len = 2;
				default: len = $urandom_range(3, 40);
			endcase
			write_reg(osv_pkg::REG_SAMPLE_LEN, len);
			case (phase % 4)
				0: write_reg(osv_pkg::REG_ROOT_NOTE, 0);
				1: write_reg(osv_pkg::REG_ROOT_NOTE, 127);
				2: write_reg(osv_pkg::REG_ROOT_NOTE, 60);
				default: write_reg(osv_pkg::REG_ROOT_NOTE, $urandom_range(0, 127));
			endcase
			cfg_write <= 1'b0;
			span = (len > 48) ? 48 : len;
			for (int a = 0; a < span; a++)
				send(make_item(osv_pkg::OP_LOAD, 0, 0, a, rand_word(), rand_word(),
					0, 0, 0, 0));
			items = 210 - span;
			for (int n = 0; n < items; n++) begin
				it = random_item(span);
				send(it);
				if (n == items / 2)
					drain();
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_frames.size() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
